// File: sv/lfu_pkg.sv
// Shared types, constants and controller states of the LFU cache table.
package lfu_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam int unsigned CountWidthDefault = 16;

  localparam int unsigned CapWidth = 7;
  localparam logic [CapWidth-1:0] CapResetValue = 7'd64;

  localparam logic signed [31:0] NotFoundValue = -32'sd1;
  localparam logic signed [31:0] NoEvictedKey = 32'sd0;

  typedef enum logic [0:0] {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic op_load;
    logic rd_issue;
    logic phase_sweep;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;
    logic need_sweep;
    logic out_busy;
  } status_t;

  typedef enum logic [7:0] {
    StClear      = 8'b0000_0001,
    StIdle       = 8'b0000_0010,
    StScan       = 8'b0000_0100,
    StScanDrain  = 8'b0000_1000,
    StDecide     = 8'b0001_0000,
    StSweep      = 8'b0010_0000,
    StSweepDrain = 8'b0100_0000,
    StDone       = 8'b1000_0000
  } state_e;

endpackage

// File: sv/lfu_ctrl.sv
// Controller state machine that sequences the clear, scan and sweep passes.
module lfu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lfu_pkg::status_t status_i,
  output lfu_pkg::cmd_t    cmd_o
);

  lfu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lfu_pkg::StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.addr_last) begin
          state_d = lfu_pkg::StIdle;
        end
      end
      lfu_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.op_load = 1'b1;
          state_d       = lfu_pkg::StScan;
        end
      end
      lfu_pkg::StScan: begin
        cmd_o.rd_issue = 1'b1;
        if (status_i.addr_last) begin
          state_d = lfu_pkg::StScanDrain;
        end
      end
      lfu_pkg::StScanDrain: begin
        state_d = lfu_pkg::StDecide;
      end
      lfu_pkg::StDecide: begin
        state_d = status_i.need_sweep ? lfu_pkg::StSweep : lfu_pkg::StDone;
      end
      lfu_pkg::StSweep: begin
        cmd_o.rd_issue    = 1'b1;
        cmd_o.phase_sweep = 1'b1;
        if (status_i.addr_last) begin
          state_d = lfu_pkg::StSweepDrain;
        end
      end
      lfu_pkg::StSweepDrain: begin
        cmd_o.phase_sweep = 1'b1;
        state_d           = lfu_pkg::StDone;
      end
      lfu_pkg::StDone: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = lfu_pkg::StIdle;
        end
      end
      default: begin
        state_d = lfu_pkg::StClear;
      end
    endcase
  end

  assign in_stall_o = (state_q != lfu_pkg::StIdle);

endmodule

// File: sv/lfu_dp.sv
// Datapath of the LFU cache table: entry memory, scan accumulators and result register.
module lfu_dp #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDefault,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::CountWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfu_pkg::cmd_t                  cmd_i,
  output lfu_pkg::status_t               status_o,
  input  lfu_pkg::in_item_t              in_item_i,
  input  logic [lfu_pkg::CapWidth-1:0]   cap_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lfu_pkg::out_item_t             out_item_o
);

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (NW > lfu_pkg::CapWidth) ? NW : lfu_pkg::CapWidth;

  typedef struct packed {
    logic                   valid;
    logic [31:0]            key;
    logic [31:0]            value;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [AW-1:0]          rank;
  } word_t;

  word_t mem [MAX_ENTRIES];
  word_t rdata_q;
  word_t wdata;
  logic  wr_en;
  logic [AW-1:0] wr_addr;

  logic [AW-1:0] addr_q, addr_d;
  logic          rd_valid_q;
  logic [AW-1:0] rd_idx_q;
  lfu_pkg::in_item_t item_q;

  // Scan accumulators.
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [31:0]   hit_value_q, hit_value_d;
  logic [AW-1:0] hit_rank_q, hit_rank_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          vic_q, vic_d;
  logic [AW-1:0] vic_idx_q, vic_idx_d;
  logic [31:0]   vic_key_q, vic_key_d;
  logic [COUNT_WIDTH-1:0] vic_cnt_q, vic_cnt_d;
  logic [AW-1:0] vic_rank_q, vic_rank_d;
  logic [NW-1:0] n_q, n_d;

  logic          out_valid_q;
  lfu_pkg::out_item_t out_item_q;

  logic scan_take, sweep_take, addr_last;
  logic is_put, cap_zero, do_touch, do_insert, do_evict, use_vic, slot_ok;
  logic [AW-1:0] slot_idx;
  lfu_pkg::out_item_t result;

  assign addr_last  = (addr_q == AW'(MAX_ENTRIES - 1));
  assign scan_take  = rd_valid_q && !cmd_i.phase_sweep;
  assign sweep_take = rd_valid_q && cmd_i.phase_sweep;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.op_load) begin
      addr_d = '0;
    end else if (cmd_i.clr_wr || cmd_i.rd_issue) begin
      addr_d = addr_last ? '0 : addr_q + AW'(1);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_value_d = hit_value_q;
    hit_rank_d  = hit_rank_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    vic_d       = vic_q;
    vic_idx_d   = vic_idx_q;
    vic_key_d   = vic_key_q;
    vic_cnt_d   = vic_cnt_q;
    vic_rank_d  = vic_rank_q;
    n_d         = n_q;
    if (cmd_i.op_load) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      vic_d  = 1'b0;
      n_d    = '0;
    end else if (scan_take) begin
      if (rdata_q.valid) begin
        n_d = n_q + NW'(1);
        if (!hit_q && (rdata_q.key == item_q.key)) begin
          hit_d       = 1'b1;
          hit_idx_d   = rd_idx_q;
          hit_value_d = rdata_q.value;
          hit_rank_d  = rdata_q.rank;
        end
        if (!vic_q || (rdata_q.cnt < vic_cnt_q) ||
            ((rdata_q.cnt == vic_cnt_q) && (rdata_q.rank > vic_rank_q))) begin
          vic_d      = 1'b1;
          vic_idx_d  = rd_idx_q;
          vic_key_d  = rdata_q.key;
          vic_cnt_d  = rdata_q.cnt;
          vic_rank_d = rdata_q.rank;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  // Plan of the operation, valid once the scan has finished.
  assign is_put    = (item_q.operation == lfu_pkg::OpPut);
  assign cap_zero  = (cap_i == '0);
  assign do_touch  = hit_q && (!is_put || !cap_zero);
  assign do_insert = !hit_q && is_put && !cap_zero;
  assign do_evict  = do_insert && vic_q &&
                     ((CmpW'(n_q) >= CmpW'(cap_i)) || (n_q == NW'(MAX_ENTRIES)));
  assign use_vic   = do_evict && (!free_q || (vic_idx_q < free_idx_q));
  assign slot_idx  = use_vic ? vic_idx_q : free_idx_q;
  assign slot_ok   = do_evict || free_q;

  always_comb begin
    wdata   = rdata_q;
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = addr_q;
      wdata   = '0;
    end else if (sweep_take) begin
      wr_en = 1'b1;
      if (do_touch) begin
        if (rd_idx_q == hit_idx_q) begin
          wdata.rank = '0;
          if (rdata_q.cnt != '1) begin
            wdata.cnt = rdata_q.cnt + COUNT_WIDTH'(1);
          end
          if (is_put) begin
            wdata.value = item_q.value;
          end
        end else if (rdata_q.valid && (rdata_q.rank < hit_rank_q)) begin
          wdata.rank = rdata_q.rank + AW'(1);
        end
      end else begin
        if (slot_ok && (rd_idx_q == slot_idx)) begin
          wdata.valid = 1'b1;
          wdata.key   = item_q.key;
          wdata.value = item_q.value;
          wdata.cnt   = COUNT_WIDTH'(1);
          wdata.rank  = '0;
        end else if (do_evict && (rd_idx_q == vic_idx_q)) begin
          wdata.valid = 1'b0;
        end else if (rdata_q.valid) begin
          if (do_evict && (rdata_q.rank > vic_rank_q)) begin
            wdata.rank = rdata_q.rank;
          end else begin
            wdata.rank = rdata_q.rank + AW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    result.found       = hit_q;
    result.read_value  = (!is_put && hit_q) ? hit_value_q : lfu_pkg::NotFoundValue;
    result.evicted     = do_evict;
    result.evicted_key = do_evict ? vic_key_q : lfu_pkg::NoEvictedKey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_valid_q  <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      rd_valid_q <= cmd_i.rd_issue;
      hit_q      <= hit_d;
      free_q     <= free_d;
      vic_q      <= vic_d;
      n_q        <= n_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= addr_q;
    hit_idx_q   <= hit_idx_d;
    hit_value_q <= hit_value_d;
    hit_rank_q  <= hit_rank_d;
    free_idx_q  <= free_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_key_q   <= vic_key_d;
    vic_cnt_q   <= vic_cnt_d;
    vic_rank_q  <= vic_rank_d;
    if (cmd_i.op_load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.out_load) begin
      out_item_q <= result;
    end
  end

  assign status_o.addr_last  = addr_last;
  assign status_o.need_sweep = do_touch || do_insert;
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sv/lfu_cache_table.sv
// Top level of the LFU cache table with least-recently-used tie break.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   lfu_pkg::in_item_t (operation, key, value)
//   out      output     out_valid_o / out_stall_i lfu_pkg::out_item_t (found, read_value,
//                                                 evicted, evicted_key)
//   cfg      input      cfg_valid_i / cfg_ready_o cache_capacity, 7 bits
//
// One transaction is processed at a time. A scan pass reads every entry through the single
// read port of the entry memory, then a decision state follows. When the operation
// changes the table (any hit that is used, any insert), a sweep pass rewrites every entry's
// recency rank. A get miss or a put with capacity zero skips the sweep pass.
// After reset a clearing pass marks every entry invalid, during which in_stall_o stays high.
// A stalled result is held in the output register while the next transaction is already
// accepted and scanned; it only waits before loading its result.
module lfu_cache_table #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDefault,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::CountWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lfu_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lfu_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfu_pkg::CapWidth-1:0] cfg_data_i
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;

  // Capacity register, always ready. Users must write only while idle; the block does not check.
  logic [lfu_pkg::CapWidth-1:0] cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CapResetValue;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // The controller walks the passes; the datapath holds the entries and the result.
  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfu_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cap_i       (cap_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A new result must never overwrite one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a stalled result");

  // A loaded result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // Once a transaction is accepted the block is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again without processing");

  // The evicted key reads zero whenever nothing was evicted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.evicted) |-> (out_item_o.evicted_key == 32'sd0))
    else $error("evicted key nonzero without eviction");

endmodule

// File: dv/lfu_checker.sv
// Result checker of the LFU cache table: predicts every result from the accepted accesses.
`timescale 1ns / 100ps
module lfu_checker #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDefault,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::CountWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  lfu_pkg::in_item_t            in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  lfu_pkg::out_item_t           out_item_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [lfu_pkg::CapWidth-1:0] cfg_data_i,
  output int                           error_count_o,
  output int                           pending_o
);

  typedef logic [COUNT_WIDTH-1:0] uses_t;
  localparam uses_t UsesMax = '1;

  // Room for predicted results that are still outstanding; the block holds at most two.
  localparam int unsigned ExpDepth = 16;

  logic [lfu_pkg::CapWidth-1:0] capacity;
  logic        slot_valid [MAX_ENTRIES];
  logic [31:0] slot_key   [MAX_ENTRIES];
  logic [31:0] slot_value [MAX_ENTRIES];
  uses_t       slot_uses  [MAX_ENTRIES];
  int unsigned slot_rank  [MAX_ENTRIES];

  lfu_pkg::out_item_t exp_mem [ExpDepth];
  lfu_pkg::out_item_t predicted;
  int unsigned exp_rd   = 0;
  int unsigned exp_wr   = 0;
  int unsigned exp_fill = 0;
  int mismatches = 0;
  int results_seen = 0;

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // A use moves the entry to rank 0, ages everything that was more recent and bumps its use count.
  function automatic void mark_used(int idx);
    for (int j = 0; j < MAX_ENTRIES; j++)
      if (slot_valid[j] && j != idx && slot_rank[j] < slot_rank[idx]) slot_rank[j]++;
    slot_rank[idx] = 0;
    if (slot_uses[idx] != UsesMax) slot_uses[idx]++;
  endfunction

  // Lowest count loses; among equal counts the highest rank (oldest touch) loses.
  function automatic int evict_coldest();
    int victim = -1;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (!slot_valid[j]) continue;
      if (victim < 0 || slot_uses[j] < slot_uses[victim] ||
          (slot_uses[j] == slot_uses[victim] && slot_rank[j] > slot_rank[victim]))
        victim = j;
    end
    if (victim >= 0) begin
      for (int j = 0; j < MAX_ENTRIES; j++)
        if (slot_valid[j] && slot_rank[j] > slot_rank[victim]) slot_rank[j]--;
      slot_valid[victim] = 1'b0;
    end
    return victim;
  endfunction

  function automatic lfu_pkg::out_item_t predict_access(lfu_pkg::in_item_t item);
    lfu_pkg::out_item_t res;
    int hit;
    int victim;
    int free_slot;
    int occupied;
    int cap_eff;
    cap_eff = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
    hit = find_key(item.key);
    res.found       = (hit >= 0);
    res.read_value  = lfu_pkg::NotFoundValue;
    res.evicted     = 1'b0;
    res.evicted_key = lfu_pkg::NoEvictedKey;
    if (item.operation == lfu_pkg::OpGet) begin
      if (hit >= 0) begin
        res.read_value = slot_value[hit];
        mark_used(hit);
      end
    end else if (cap_eff != 0) begin
      if (hit >= 0) begin
        slot_value[hit] = item.value;
        mark_used(hit);
      end else begin
        occupied = 0;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot_valid[i]) occupied++;
        // With the capacity lowered below occupancy only one entry goes per insert.
        if (occupied >= cap_eff) begin
          victim = evict_coldest();
          if (victim >= 0) begin
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[victim];
          end
        end
        free_slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (!slot_valid[i]) begin
            free_slot = i;
            break;
          end
        if (free_slot >= 0) begin
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i]) slot_rank[i]++;
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = item.key;
          slot_value[free_slot] = item.value;
          slot_uses[free_slot]  = 1;
          slot_rank[free_slot]  = 0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: result %0d: %s is %h, expected %h", $time, results_seen, what, got, want);
  endtask

  task automatic check_result(lfu_pkg::out_item_t got);
    lfu_pkg::out_item_t want;
    results_seen++;
    if (exp_fill == 0) begin
      report_mismatch("transaction with no access outstanding", 32'(got.found), 32'd0);
      return;
    end
    want     = exp_mem[exp_rd];
    exp_rd   = (exp_rd + 1) % ExpDepth;
    exp_fill = exp_fill - 1;
    if (got.found !== want.found) report_mismatch("found", 32'(got.found), 32'(want.found));
    if (got.read_value !== want.read_value)
      report_mismatch("read_value", got.read_value, want.read_value);
    if (got.evicted !== want.evicted)
      report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
    if (got.evicted_key !== want.evicted_key)
      report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
  endtask

  // Results are checked before the access of the same edge is predicted, since a result
  // always belongs to an earlier access.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = lfu_pkg::CapResetValue;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_uses[i]  = '0;
        slot_rank[i]  = 0;
      end
      exp_rd   = 0;
      exp_wr   = 0;
      exp_fill = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        predicted = predict_access(in_item_i);
        if (exp_fill == ExpDepth) begin
          report_mismatch("outstanding accesses", 32'(exp_fill), 32'(ExpDepth - 1));
        end else begin
          exp_mem[exp_wr] = predicted;
          exp_wr          = (exp_wr + 1) % ExpDepth;
          exp_fill        = exp_fill + 1;
        end
      end
    end
    pending_o     <= int'(exp_fill);
    error_count_o <= mismatches;
  end

endmodule

// File: dv/testbench.sv
// Top of the LFU cache table testbench: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 100ps
module testbench;

  // The use counter is built narrow so that saturation is reached within a few accesses.
  localparam int unsigned Entries     = 64;
  localparam int unsigned UseBits     = 3;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 2 * Entries + 10;
  localparam int unsigned PoolSize    = 96;
  localparam int unsigned HoldCycles  = 600;

  localparam logic [31:0] KeyMin  = 32'h8000_0000;
  localparam logic [31:0] KeyMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  logic clk;
  logic rst_n = 1'b0;

  // Every input of the block starts at a known value.
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  lfu_pkg::in_item_t            in_item   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  lfu_pkg::out_item_t           out_item;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lfu_pkg::CapWidth-1:0] cfg_data  = '0;

  // Receiver controls, written by the stimulus process and read by the receiver process.
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;

  int failures;
  int pending;

  logic [31:0] key_pool [PoolSize];

  lfu_cache_table #(
    .MAX_ENTRIES(Entries),
    .COUNT_WIDTH(UseBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  lfu_checker #(
    .MAX_ENTRIES(Entries),
    .COUNT_WIDTH(UseBits)
  ) result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .error_count_o(failures),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends a hung run. Its limit is far above the slowest correct run, gaps of
  // both sides included.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // The receiver stalls at random, except for one long hold-off that lets the output
  // register and the access behind it fill, so that the block stalls its input.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one access and returns at the edge where it was taken. Valid is only lowered
  // when the sender idles, so back-to-back transactions keep it high.
  task automatic send_access(lfu_pkg::op_e op, logic [31:0] item_key,
                             logic [31:0] item_value, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{operation: op, key: item_key, value: item_value};
    do @(posedge clk); while (in_stall);
  endtask

  // The checker's count is registered, so it is only trusted after the next edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lfu_pkg::CapWidth-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Directed accesses: empty-table miss, extreme keys and values, update on hit, counter
  // saturation, capacity lowered below occupancy with a tie on the use count, and
  // capacity zero, where puts report presence but change nothing.
  task automatic run_directed();
    recv_idle_pct <= 86;
    send_access(lfu_pkg::OpGet, 32'd0, AllOnes, 34);
    send_access(lfu_pkg::OpPut, KeyMin, KeyMax, 34);
    send_access(lfu_pkg::OpPut, KeyMax, KeyMin, 34);
    send_access(lfu_pkg::OpGet, KeyMin, 32'd0, 34);
    send_access(lfu_pkg::OpPut, KeyMin, AllOnes, 34);
    // Eight uses take the count of KeyMax past its maximum.
    repeat (8) send_access(lfu_pkg::OpGet, KeyMax, 32'd0, 34);
    send_access(lfu_pkg::OpPut, 32'h5555_5555, 32'h1234_5678, 34);
    send_access(lfu_pkg::OpPut, 32'hAAAA_AAAA, 32'h8765_4321, 34);
    // Four entries stay behind a capacity of two; each insert replaces exactly one, and
    // the two entries with a count of one are told apart by age.
    write_capacity(7'd2);
    send_access(lfu_pkg::OpPut, AllOnes, 32'd0, 34);
    send_access(lfu_pkg::OpPut, 32'd1, 32'd1, 34);
    send_access(lfu_pkg::OpGet, 32'h5555_5555, 32'd0, 34);
    write_capacity(7'd0);
    send_access(lfu_pkg::OpPut, KeyMax, 32'd5, 34);
    send_access(lfu_pkg::OpPut, 32'd2, 32'd2, 34);
    send_access(lfu_pkg::OpGet, KeyMax, 32'd0, 34);
  endtask

  // Most keys come from a pool a little larger than the capacity, so that hits, updates
  // and evictions are frequent; the rest are fully random and nearly always miss.
  task automatic run_random_phase(logic [lfu_pkg::CapWidth-1:0] cap, int count,
                                  int send_pct, int recv_pct, bit with_hold);
    int          eff;
    int          span;
    lfu_pkg::op_e op;
    logic [31:0] item_key;
    logic [31:0] item_value;
    write_capacity(cap);
    recv_idle_pct <= recv_pct;
    eff  = (cap > Entries) ? Entries : int'(cap);
    span = (eff == 0) ? PoolSize : eff + eff / 2 + 4;
    if (span > PoolSize) span = PoolSize;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 3) hold_req <= 1'b1;
      op = lfu_pkg::op_e'($urandom_range(1));
      if ($urandom_range(99) < 78) item_key = key_pool[$urandom_range(span - 1)];
      else item_key = $urandom();
      item_value = $urandom();
      send_access(op, item_key, item_value, send_pct);
    end
  endtask

  initial begin : stimulus
    key_pool[0] = 32'd0;
    key_pool[1] = AllOnes;
    key_pool[2] = KeyMin;
    key_pool[3] = KeyMax;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = $urandom();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Sender idles 34 percent and receiver 86 percent, then the reverse, then neither.
    // The second phase drops the table to a capacity of two, and the capacity of 127
    // lies above the table size.
    run_random_phase(7'd64, 110, 34, 86, 1'b0);
    run_random_phase(7'd2, 90, 34, 86, 1'b0);
    run_random_phase(7'd127, 110, 86, 34, 1'b0);
    run_random_phase(7'd0, 60, 86, 34, 1'b0);
    run_random_phase(7'd17, 110, 0, 0, 1'b1);
    run_random_phase(7'd1, 100, 0, 0, 1'b0);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0 && pending == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/lfu_pkg.sv
sv/lfu_ctrl.sv
sv/lfu_dp.sv
sv/lfu_cache_table.sv
dv/lfu_checker.sv
dv/testbench.sv
